>>> sv/lsf_pkg.sv
// ----------------------------------------------------------------------------
// lsf_pkg: shared types and constants for the line substring filter
// Pattern geometry, register indexes and the structs passed between stages.
// ----------------------------------------------------------------------------
package lsf_pkg;

  localparam int MAX_PATTERN = 30;
  localparam int LINE_LIMIT  = 256;

  localparam int BYTE_W    = 8;
  localparam int PLEN_W    = 5;
  localparam int PIDX_W    = $clog2(MAX_PATTERN);
  localparam int CNT_W     = $clog2(LINE_LIMIT + 1);
  localparam int LEN_OUT_W = 9;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int PAT_W     = MAX_PATTERN * BYTE_W;

  localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'd10;
  localparam logic [BYTE_W-1:0] CHAR_NUL     = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_0_7   = 3'd0,
    REG_PAT_8_15  = 3'd1,
    REG_PAT_16_23 = 3'd2,
    REG_PAT_24_29 = 3'd3,
    REG_PAT_LEN   = 3'd4
  } reg_idx_e;

  // Pattern prepared for the window compare: entry k lines up with the
  // window byte k positions back from the newest one.
  typedef struct packed {
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] bytes;
    logic [MAX_PATTERN-1:0]             mask;
    logic [PLEN_W-1:0]                  len;
  } pat_t;

  typedef struct packed {
    logic                 line_end;
    logic                 matched;
    logic [LEN_OUT_W-1:0] length;
  } res_t;

endpackage

>>> sv/lsf_cfg.sv
// ----------------------------------------------------------------------------
// lsf_cfg: configuration registers and pattern alignment
// Holds the pattern registers and registers a window-aligned copy of them.
// ----------------------------------------------------------------------------
module lsf_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lsf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lsf_pkg::CFG_W-1:0]      cfg_data_i,
  output lsf_pkg::pat_t                  pat_o
);
  import lsf_pkg::*;

  logic [PAT_W-1:0]  pat_q, pat_d;
  logic [PLEN_W-1:0] plen_q, plen_d;
  logic [MAX_PATTERN-1:0][BYTE_W-1:0] pat_bytes;
  logic [PLEN_W-1:0] n_clamped;
  pat_t              align_q, align_d;

  assign pat_bytes = pat_q;

  always_comb begin
    pat_d  = pat_q;
    plen_d = plen_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_PAT_0_7:   pat_d[63:0]    = cfg_data_i;
        REG_PAT_8_15:  pat_d[127:64]  = cfg_data_i;
        REG_PAT_16_23: pat_d[191:128] = cfg_data_i;
        REG_PAT_24_29: pat_d[239:192] = cfg_data_i[47:0];
        REG_PAT_LEN:   plen_d         = cfg_data_i[PLEN_W-1:0];
        default:       pat_d          = pat_q;
      endcase
    end
  end

  assign n_clamped = (plen_q > PLEN_W'(MAX_PATTERN)) ? PLEN_W'(MAX_PATTERN) : plen_q;

  // Pattern byte j faces window byte n-1-j, so the last pattern byte meets
  // the newest text byte.
  always_comb begin
    logic [PIDX_W-1:0] idx;
    idx = '0;
    align_d.len = n_clamped;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      idx = PIDX_W'(n_clamped) - PIDX_W'(1) - PIDX_W'(k);
      if (n_clamped > PLEN_W'(k)) begin
        align_d.mask[k]  = 1'b1;
        align_d.bytes[k] = pat_bytes[idx];
      end else begin
        align_d.mask[k]  = 1'b0;
        align_d.bytes[k] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q   <= '0;
      plen_q  <= '0;
      align_q <= '0;
    end else begin
      pat_q   <= pat_d;
      plen_q  <= plen_d;
      align_q <= align_d;
    end
  end

  assign pat_o = align_q;

endmodule

>>> sv/lsf_scan.sv
// ----------------------------------------------------------------------------
// lsf_scan: byte window, line counter and match flag
// Shifts line bytes into the window and compares it with the pattern.
// ----------------------------------------------------------------------------
module lsf_scan (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        go_i,
  input  logic [lsf_pkg::BYTE_W-1:0]  byte_i,
  input  lsf_pkg::pat_t               pat_i,
  output lsf_pkg::res_t               res_o
);
  import lsf_pkg::*;

  logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_q, win_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
  logic             match_q, match_d;
  logic             line_end;
  logic             hit;
  logic [MAX_PATTERN-1:0] pos_ok;

  assign line_end = (byte_i == CHAR_NEWLINE) || (byte_i == CHAR_NUL) ||
                    (cnt_q >= CNT_W'(LINE_LIMIT));
  assign cnt_inc  = cnt_q + CNT_W'(1);

  always_comb begin
    win_d[0] = byte_i;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_d[k] = win_q[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      pos_ok[k] = !pat_i.mask[k] || (win_d[k] == pat_i.bytes[k]);
    end
  end

  // The count guard keeps stale bytes of earlier lines out of the compare.
  assign hit = (pat_i.len != '0) && (&pos_ok) && (cnt_inc >= CNT_W'(pat_i.len));

  always_comb begin
    cnt_d   = cnt_q;
    match_d = match_q;
    if (go_i) begin
      if (line_end) begin
        cnt_d   = '0;
        match_d = 1'b0;
      end else begin
        cnt_d   = cnt_inc;
        match_d = match_q || hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      match_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i && !line_end) begin
      win_q <= win_d;
    end
  end

  assign res_o.line_end = line_end;
  assign res_o.matched  = match_q || (pat_i.len == '0);
  assign res_o.length   = LEN_OUT_W'(cnt_q);

endmodule

>>> sv/line_substring_filter_top.sv
// ----------------------------------------------------------------------------
// line_substring_filter_top: per-line substring search over a byte stream
// Reports for each text line whether the configured pattern occurs in it.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle, back to back, while the input is
// not stalled, and gives one result per line end (newline, NUL, or a byte
// arriving once the line is full). An accepted byte sits in an input register
// while the window is shifted and all pattern positions are compared in
// parallel; a line end then loads the result register, from which the result
// is taken. Input stalls only when a line end meets a full result register
// that is itself stalled. A configuration write reaches the pattern registers
// and then their window-aligned copy, which the compare uses.
module line_substring_filter_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lsf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lsf_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [lsf_pkg::BYTE_W-1:0]     text_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           line_matched_o,
  output logic [lsf_pkg::LEN_OUT_W-1:0]  line_length_o
);
  import lsf_pkg::*;

  pat_t              pat;
  res_t              res;
  logic              a_valid_q, a_valid_d;
  logic [BYTE_W-1:0] a_byte_q;
  logic              a_go;
  logic              in_accept;
  logic              out_free;
  logic              out_valid_q, out_valid_d;
  logic              out_matched_q;
  logic [LEN_OUT_W-1:0] out_length_q;
  logic              out_load;

  lsf_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pat_o      (pat)
  );

  lsf_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (a_go),
    .byte_i (a_byte_q),
    .pat_i  (pat),
    .res_o  (res)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign a_go       = a_valid_q && (!res.line_end || out_free);
  assign in_stall_o = a_valid_q && !a_go;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = a_go && res.line_end;

  always_comb begin
    a_valid_d = a_valid_q;
    if (in_accept) begin
      a_valid_d = 1'b1;
    end else if (a_go) begin
      a_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_byte_q <= text_byte_i;
    end
    if (out_load) begin
      out_matched_q <= res.matched;
      out_length_q  <= res.length;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign line_matched_o = out_matched_q;
  assign line_length_o  = out_length_q;

  // A new result can only come from a byte held in the input register.
  a_rise_from_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(a_valid_q))
    else $error("result appeared without a pending input byte");

  // Input back-pressure only arises from a full, stalled result register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && res.line_end))
    else $error("input stalled without a blocked line end");

  // A reported line never holds more bytes than the line limit.
  a_length_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (line_length_o <= LEN_OUT_W'(LINE_LIMIT)))
    else $error("line length beyond the line limit");

endmodule
